FILE: hw/rtl/checked_16bit_alu_defines.svh
// assertion macros for the rtl
`ifndef CHECKED_16BIT_ALU_DEFINES_SVH
`define CHECKED_16BIT_ALU_DEFINES_SVH

// property that must hold on every clock outside reset
`define CAL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked on every clock outside reset
`define CAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cal_pkg.sv
package cal_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned NUM_CELLS = WORD_W;

  typedef enum logic [3:0] {
    OP_MUL = 4'd0,
    OP_DIV = 4'd1,
    OP_MOD = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_SHL = 4'd5,
    OP_SHR = 4'd6,
    OP_AND = 4'd7,
    OP_XOR = 4'd8,
    OP_OR  = 4'd9
  } cal_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2
  } cal_status_t;

  // item as it travels down the cell chain
  typedef struct packed {
    logic [3:0]        op;
    logic [WORD_W-1:0] rem;      // partial remainder
    logic [WORD_W-1:0] dq;       // dividend shifting out, quotient shifting in
    logic [WORD_W-1:0] divisor;
    logic [WORD_W-1:0] value;    // result of every non-division op
    cal_status_t       status;
  } cal_item_t;

endpackage

FILE: hw/rtl/cal_in_if.sv
interface cal_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [15:0] left_operand;
  logic [15:0] right_operand;

  modport source (output valid, output op, output left_operand, output right_operand,
                  input ready);
  modport sink (input valid, input op, input left_operand, input right_operand,
                output ready);
endinterface

FILE: hw/rtl/cal_out_if.sv
interface cal_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_value;
  logic [1:0]  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

FILE: hw/rtl/cal_front.sv
module cal_front import cal_pkg::*; (
  input  logic [3:0]        op,
  input  logic [WORD_W-1:0] left_operand,
  input  logic [WORD_W-1:0] right_operand,
  output cal_item_t         item
);

  logic [2*WORD_W-1:0] prod;
  logic [WORD_W:0]     sum;
  logic [WORD_W-1:0]   hi_mask;
  logic                big_shift;
  logic [3:0]          sh;

  assign prod      = {{WORD_W{1'b0}}, left_operand} * {{WORD_W{1'b0}}, right_operand};
  assign sum       = {1'b0, left_operand} + {1'b0, right_operand};
  assign sh        = right_operand[3:0];
  assign big_shift = |right_operand[WORD_W-1:4];
  // bits that a left shift pushes out past the top
  assign hi_mask   = ~({WORD_W{1'b1}} >> sh);

  always_comb begin
    item.op      = op;
    item.rem     = '0;
    item.dq      = left_operand;
    item.divisor = right_operand;
    item.value   = '0;
    item.status  = ST_OK;
    case (cal_op_t'(op))
      OP_MUL: begin
        if (|prod[2*WORD_W-1:WORD_W]) item.status = ST_OVERFLOW;
        else item.value = prod[WORD_W-1:0];
      end
      OP_DIV, OP_MOD: begin
        if (right_operand == '0) item.status = ST_DIVZERO;
      end
      OP_ADD: begin
        if (sum[WORD_W]) item.status = ST_OVERFLOW;
        else item.value = sum[WORD_W-1:0];
      end
      OP_SUB: begin
        if (left_operand < right_operand) item.status = ST_OVERFLOW;
        else item.value = left_operand - right_operand;
      end
      OP_SHL: begin
        if (left_operand == '0) item.value = '0;
        else if (big_shift || ((left_operand & hi_mask) != '0)) item.status = ST_OVERFLOW;
        else item.value = left_operand << sh;
      end
      OP_SHR: begin
        item.value = big_shift ? '0 : (left_operand >> sh);
      end
      OP_AND: item.value = left_operand & right_operand;
      OP_XOR: item.value = left_operand ^ right_operand;
      OP_OR:  item.value = left_operand | right_operand;
      default: item.value = '0;
    endcase
  end

endmodule

FILE: hw/rtl/cal_div_cell.sv
module cal_div_cell import cal_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  cal_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output cal_item_t dn_item
);

  cal_item_t       item_next;
  logic [WORD_W:0] trial;

  // one restoring division step: one quotient bit
  assign trial = {up_item.rem, up_item.dq[WORD_W-1]} - {1'b0, up_item.divisor};

  always_comb begin
    item_next = up_item;
    if (!trial[WORD_W]) begin
      item_next.rem = trial[WORD_W-1:0];
      item_next.dq  = {up_item.dq[WORD_W-2:0], 1'b1};
    end else begin
      item_next.rem = {up_item.rem[WORD_W-2:0], up_item.dq[WORD_W-1]};
      item_next.dq  = {up_item.dq[WORD_W-2:0], 1'b0};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/checked_16bit_alu.sv
// checked 16-bit unsigned alu
// cmd channel: op, left_operand, right_operand; a transfer happens when
//   valid and ready are both high at a rising clk edge
// rsp channel: result_value and status (ok, overflow/underflow, zero divisor);
//   result_value is zero whenever status is not ok
// path: a cmd transfer reaches rsp valid through 16 division cells and then
//   the output register; a receiver stall holds it back longer
// throughput: one item per cycle unless the receiver stalls, set by the
//   division cells, each resolving one quotient bit and passing the item on each cycle
// every op travels the full chain so results leave in order
// reset (rst, synchronous) empties the chain and the output register
// when the receiver stalls, the output register holds its result and the
//   cells behind it keep filling any empty slots; cmd ready drops only once
//   every cell up to the input is occupied
`include "checked_16bit_alu_defines.svh"

module checked_16bit_alu import cal_pkg::*; (
  input logic      clk,
  input logic      rst,
  cal_in_if.sink   cmd,
  cal_out_if.source rsp
);

  logic [NUM_CELLS:0] valid_c;
  logic [NUM_CELLS:0] ready_c;
  cal_item_t          item_c [NUM_CELLS+1];

  logic [WORD_W-1:0]  result_next;

  // decode and compute every non-division op up front
  cal_front u_front (
    .op            (cmd.op),
    .left_operand  (cmd.left_operand),
    .right_operand (cmd.right_operand),
    .item          (item_c[0])
  );

  assign valid_c[0] = cmd.valid;
  assign cmd.ready  = ready_c[0];

  // chain of division cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cal_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid_c[i]),
      .up_ready (ready_c[i]),
      .up_item  (item_c[i]),
      .dn_valid (valid_c[i+1]),
      .dn_ready (ready_c[i+1]),
      .dn_item  (item_c[i+1])
    );
  end

  // output register parts the chain from the receiver
  assign ready_c[NUM_CELLS] = !rsp.valid || rsp.ready;

  always_comb begin
    result_next = item_c[NUM_CELLS].value;
    if (item_c[NUM_CELLS].status == ST_OK) begin
      case (cal_op_t'(item_c[NUM_CELLS].op))
        OP_DIV:  result_next = item_c[NUM_CELLS].dq;
        OP_MOD:  result_next = item_c[NUM_CELLS].rem;
        default: result_next = item_c[NUM_CELLS].value;
      endcase
    end else begin
      result_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ready_c[NUM_CELLS]) begin
      rsp.valid <= valid_c[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c[NUM_CELLS] && valid_c[NUM_CELLS]) begin
      rsp.result_value <= result_next;
      rsp.status       <= item_c[NUM_CELLS].status;
    end
  end

  // a failed op never carries a value
  `CAL_ASSERT_IMPL(a_err_zero, rsp.valid && (rsp.status != ST_OK), rsp.result_value == '0, "nonzero result with error status")
  // a finished division leaves a remainder below its divisor
  `CAL_ASSERT_IMPL(a_rem_range, valid_c[NUM_CELLS] && (item_c[NUM_CELLS].divisor != '0), item_c[NUM_CELLS].rem < item_c[NUM_CELLS].divisor, "remainder not below divisor")
  // an empty output register means nothing in the chain can be stuck
  `CAL_ASSERT_IMPL(a_ready_free, !rsp.valid, cmd.ready, "cmd not ready with empty output")

endmodule
